FILE: sv/servo_status_packet_receiver_top_assert.svh
// Assertion macros shared by the receiver RTL.
`ifndef SERVO_STATUS_PACKET_RECEIVER_TOP_ASSERT_SVH
`define SERVO_STATUS_PACKET_RECEIVER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define SSPRX_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SSPRX_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SSPRX_ASSERT(lbl, clk, rst_n, prop, msg)
`define SSPRX_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: sv/ssprx_pkg.sv
`timescale 1ns / 1ps
package ssprx_pkg;

  localparam int CNT_W = 6;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [7:0] HEADER_BYTE = 8'hFF;
  localparam logic [7:0] MIN_LENGTH = 8'd2;

  localparam logic CFG_EXPECTED_ID = 1'b0;
  localparam logic CFG_TIMEOUT_TICKS = 1'b1;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_TICK  = 2'd1,
    OP_START = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HDR1,
    PH_HDR2,
    PH_ID,
    PH_LEN,
    PH_ERR,
    PH_PARAM,
    PH_CHK
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TIMEOUT    = 3'd1,
    ST_BADLEN     = 3'd2,
    ST_BADSUM     = 3'd3,
    ST_IDMISMATCH = 3'd4,
    ST_SERVOERR   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CMD_STORE,
    CMD_SINGLE,
    CMD_FINISH
  } cmd_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_SEND
  } back_state_t;

  typedef struct packed {
    cmd_kind_t        kind;
    status_t          status;
    logic [7:0]       id;
    logic [7:0]       err;
    logic [7:0]       data;
    logic [CNT_W-1:0] idx;
    logic [CNT_W-1:0] count;
  } cmd_t;

endpackage

FILE: sv/ssprx_in_if.sv
`timescale 1ns / 1ps
interface ssprx_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

FILE: sv/ssprx_out_if.sv
`timescale 1ns / 1ps
interface ssprx_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] servo_id;
  logic [7:0] error_flags;
  logic [7:0] param_byte;
  logic [2:0] param_index;
  logic [2:0] param_count;
  logic       last;

  modport source (output valid, output status, output servo_id, output error_flags,
                  output param_byte, output param_index, output param_count,
                  output last, input ready);
  modport sink (input valid, input status, input servo_id, input error_flags,
                input param_byte, input param_index, input param_count,
                input last, output ready);
endinterface

FILE: sv/servo_status_packet_receiver_top.sv
// Servo status packet receiver.
// Input: one item per cycle while the 4-entry command queue has room.
// Timeout, bad length and parameter-free packets give one result, loaded from the queue head into
// the output register; packets with parameters give one result per parameter, each read from the
// parameter memory and then sent, and the back end takes no new command until the last is sent.
// Reset (rst_n low, synchronous): disarmed, queue empty, expected_id 1, timeout_ticks 10.
`timescale 1ns / 1ps
module servo_status_packet_receiver_top
  import ssprx_pkg::*;
#(
  parameter int MAX_LENGTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  ssprx_in_if.sink    in_ch,
  ssprx_out_if.source out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  cmd_t push_cmd;
  cmd_t head;
  logic push;
  logic pop;
  logic q_empty;
  logic q_full;

  ssprx_front #(.MAX_LENGTH(MAX_LENGTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (push),
    .q_cmd     (push_cmd)
  );

  ssprx_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  ssprx_back #(.MAX_LENGTH(MAX_LENGTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (head),
    .cmd_valid (!q_empty),
    .cmd_pop   (pop),
    .out_ch    (out_ch)
  );

endmodule

FILE: sv/ssprx_front.sv
`timescale 1ns / 1ps
module ssprx_front
  import ssprx_pkg::*;
#(
  parameter int MAX_LENGTH = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  ssprx_in_if.sink      in_ch,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [7:0]    cfg_data,
  input  logic          q_full,
  output logic          q_push,
  output cmd_t          q_cmd
);

  phase_t           phase_r, phase_nxt;
  logic [7:0]       tick_r, tick_nxt;
  logic [7:0]       id_r, id_nxt;
  logic [7:0]       len_r, len_nxt;
  logic [7:0]       err_r, err_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [CNT_W-1:0] bc_r, bc_nxt;
  logic [7:0]       expected_id_r;
  logic [7:0]       timeout_r;
  logic             accept;
  logic [7:0]       b;
  status_t          chk_status;

  assign in_ch.ready = !q_full;
  assign accept = in_ch.valid && !q_full;
  assign b = in_ch.rx_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_id_r <= 8'd1;
      timeout_r <= 8'd10;
    end else if (cfg_we) begin
      if (cfg_index == CFG_EXPECTED_ID) begin
        expected_id_r <= cfg_data;
      end else begin
        timeout_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r <= '0;
      id_r <= '0;
      len_r <= '0;
      err_r <= '0;
      sum_r <= '0;
      bc_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      tick_r <= tick_nxt;
      id_r <= id_nxt;
      len_r <= len_nxt;
      err_r <= err_nxt;
      sum_r <= sum_nxt;
      bc_r <= bc_nxt;
    end
  end

  always_comb begin
    if ((~sum_r) != b) begin
      chk_status = ST_BADSUM;
    end else if (id_r != expected_id_r) begin
      chk_status = ST_IDMISMATCH;
    end else if (err_r != 8'd0) begin
      chk_status = ST_SERVOERR;
    end else begin
      chk_status = ST_OK;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    tick_nxt = tick_r;
    id_nxt = id_r;
    len_nxt = len_r;
    err_nxt = err_r;
    sum_nxt = sum_r;
    bc_nxt = bc_r;
    q_push = 1'b0;
    q_cmd = '0;
    q_cmd.kind = CMD_SINGLE;
    q_cmd.status = ST_OK;
    if (accept) begin
      case (in_ch.operation)
        OP_START: begin
          phase_nxt = PH_HDR1;
          tick_nxt = '0;
          bc_nxt = '0;
        end
        OP_TICK: begin
          if (phase_r != PH_IDLE) begin
            if (tick_r >= timeout_r) begin
              phase_nxt = PH_IDLE;
              q_push = 1'b1;
              q_cmd.status = ST_TIMEOUT;
            end else begin
              tick_nxt = tick_r + 8'd1;
            end
          end
        end
        OP_BYTE: begin
          case (phase_r)
            PH_HDR1: begin
              if (b == HEADER_BYTE) begin
                phase_nxt = PH_HDR2;
              end
            end
            PH_HDR2: begin
              phase_nxt = (b == HEADER_BYTE) ? PH_ID : PH_HDR1;
            end
            PH_ID: begin
              id_nxt = b;
              sum_nxt = b;
              phase_nxt = PH_LEN;
            end
            PH_LEN: begin
              len_nxt = b;
              if (b < MIN_LENGTH || b > 8'(MAX_LENGTH)) begin
                phase_nxt = PH_IDLE;
                q_push = 1'b1;
                q_cmd.status = ST_BADLEN;
                q_cmd.id = id_r;
              end else begin
                sum_nxt = sum_r + b;
                tick_nxt = '0;
                phase_nxt = PH_ERR;
              end
            end
            PH_ERR: begin
              err_nxt = b;
              sum_nxt = sum_r + b;
              bc_nxt = '0;
              phase_nxt = (len_r > MIN_LENGTH) ? PH_PARAM : PH_CHK;
            end
            PH_PARAM: begin
              q_push = 1'b1;
              q_cmd.kind = CMD_STORE;
              q_cmd.data = b;
              q_cmd.idx = bc_r;
              sum_nxt = sum_r + b;
              bc_nxt = bc_r + CNT_W'(1);
              if (8'(bc_r) + 8'd3 >= len_r) begin
                phase_nxt = PH_CHK;
              end
            end
            PH_CHK: begin
              phase_nxt = PH_IDLE;
              q_push = 1'b1;
              q_cmd.status = chk_status;
              q_cmd.id = id_r;
              q_cmd.err = err_r;
              if (len_r != MIN_LENGTH) begin
                q_cmd.kind = CMD_FINISH;
                q_cmd.count = CNT_W'(len_r - MIN_LENGTH);
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: sv/ssprx_queue.sv
`timescale 1ns / 1ps
`include "servo_status_packet_receiver_top_assert.svh"
module ssprx_queue
  import ssprx_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  cmd_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full = (count_r == (QPTR_W + 1)'(QDEPTH));
  assign head = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (QPTR_W + 1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

  `SSPRX_ASSERT(a_no_overflow, clk, rst_n, push |-> !full, "push into full queue")
  `SSPRX_ASSERT(a_no_underflow, clk, rst_n, pop |-> !empty, "pop from empty queue")
  `SSPRX_ASSERT(a_count_bound, clk, rst_n, count_r <= (QPTR_W + 1)'(QDEPTH), "queue over depth")

endmodule

FILE: sv/ssprx_back.sv
`timescale 1ns / 1ps
`include "servo_status_packet_receiver_top_assert.svh"
module ssprx_back
  import ssprx_pkg::*;
#(
  parameter int MAX_LENGTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  input  logic        cmd_valid,
  output logic        cmd_pop,
  ssprx_out_if.source out_ch
);

  localparam int SLOTS = (MAX_LENGTH > 2) ? MAX_LENGTH - 2 : 1;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  back_state_t      st_r, st_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  status_t          est_r, est_nxt;
  logic [7:0]       eid_r, eid_nxt;
  logic [7:0]       eerr_r, eerr_nxt;
  logic [7:0]       mem [SLOTS];
  logic [7:0]       rdata_r;
  logic             mem_we;

  logic             out_valid_r, out_valid_nxt;
  logic [2:0]       out_status_r, out_status_nxt;
  logic [7:0]       out_id_r, out_id_nxt;
  logic [7:0]       out_err_r, out_err_nxt;
  logic [7:0]       out_pb_r, out_pb_nxt;
  logic [2:0]       out_pi_r, out_pi_nxt;
  logic [2:0]       out_pc_r, out_pc_nxt;
  logic             out_last_r, out_last_nxt;
  logic             slot_free;
  logic             send_last;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign send_last = (idx_r + CNT_W'(1) == cnt_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cmd.idx[IDX_W-1:0]] <= cmd.data;
    end
    rdata_r <= mem[idx_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    cnt_r <= cnt_nxt;
    est_r <= est_nxt;
    eid_r <= eid_nxt;
    eerr_r <= eerr_nxt;
    out_status_r <= out_status_nxt;
    out_id_r <= out_id_nxt;
    out_err_r <= out_err_nxt;
    out_pb_r <= out_pb_nxt;
    out_pi_r <= out_pi_nxt;
    out_pc_r <= out_pc_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    st_nxt = st_r;
    idx_nxt = idx_r;
    cnt_nxt = cnt_r;
    est_nxt = est_r;
    eid_nxt = eid_r;
    eerr_nxt = eerr_r;
    cmd_pop = 1'b0;
    mem_we = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_id_nxt = out_id_r;
    out_err_nxt = out_err_r;
    out_pb_nxt = out_pb_r;
    out_pi_nxt = out_pi_r;
    out_pc_nxt = out_pc_r;
    out_last_nxt = out_last_r;
    case (st_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            CMD_STORE: begin
              cmd_pop = 1'b1;
              mem_we = 1'b1;
            end
            CMD_SINGLE: begin
              if (slot_free) begin
                cmd_pop = 1'b1;
                out_valid_nxt = 1'b1;
                out_status_nxt = cmd.status;
                out_id_nxt = cmd.id;
                out_err_nxt = cmd.err;
                out_pb_nxt = '0;
                out_pi_nxt = '0;
                out_pc_nxt = '0;
                out_last_nxt = 1'b1;
              end
            end
            CMD_FINISH: begin
              cmd_pop = 1'b1;
              idx_nxt = '0;
              cnt_nxt = cmd.count;
              est_nxt = cmd.status;
              eid_nxt = cmd.id;
              eerr_nxt = cmd.err;
              st_nxt = BK_READ;
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      BK_READ: begin
        st_nxt = BK_SEND;
      end
      BK_SEND: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_status_nxt = est_r;
          out_id_nxt = eid_r;
          out_err_nxt = eerr_r;
          out_pb_nxt = rdata_r;
          out_pi_nxt = idx_r[2:0];
          out_pc_nxt = cnt_r[2:0];
          out_last_nxt = send_last;
          if (send_last) begin
            st_nxt = BK_IDLE;
          end else begin
            idx_nxt = idx_r + CNT_W'(1);
            st_nxt = BK_READ;
          end
        end
      end
      default: begin
        st_nxt = BK_IDLE;
      end
    endcase
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.servo_id = out_id_r;
  assign out_ch.error_flags = out_err_r;
  assign out_ch.param_byte = out_pb_r;
  assign out_ch.param_index = out_pi_r;
  assign out_ch.param_count = out_pc_r;
  assign out_ch.last = out_last_r;

  `SSPRX_ASSERT(a_no_pop_in_burst, clk, rst_n, (st_r != BK_IDLE) |-> !cmd_pop, "pop during emit")
  `SSPRX_ASSERT(a_send_loads, clk, rst_n, (st_r == BK_SEND) && slot_free |=> out_valid_r, "send lost")

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import ssprx_pkg::*;

  localparam int MAX_LEN = 8;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    status_t    status;
    logic [7:0] servo_id;
    logic [7:0] error_flags;
    logic [7:0] param_byte;
    logic [2:0] param_index;
    logic [2:0] param_count;
    logic       last;
  } servo_result_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
  } rx_item_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic       cfg_index = CFG_EXPECTED_ID;
  logic [7:0] cfg_data = 8'h00;

  ssprx_in_if  in_ch();
  ssprx_out_if out_ch();

  servo_status_packet_receiver_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  rx_item_t      rx_feed[$];
  servo_result_t due_results[$];
  int            queued_cnt = 0;
  int            fail_cnt = 0;
  int            src_idle_pct = 0;
  int            sink_idle_pct = 0;
  int            hold_left = 0;
  bit            hold_req = 1'b0;
  bit            hold_seen = 1'b0;

  // receiver shadow state
  logic [7:0] want_id = 8'd1;
  logic [7:0] tick_limit = 8'd10;
  phase_t     rx_phase = PH_IDLE;
  logic [7:0] rx_ticks = 8'd0;
  logic [7:0] rx_id = 8'd0;
  logic [7:0] rx_len = 8'd0;
  logic [7:0] rx_err = 8'd0;
  logic [7:0] rx_sum = 8'd0;
  int         rx_nparam = 0;
  logic [7:0] rx_params [6];

  function automatic void parse_rx_item(logic [1:0] op, logic [7:0] b);
    servo_result_t r;
    status_t       st;
    logic [7:0]    want_chk;
    int            n;
    r = '0;
    r.last = 1'b1;
    if (op == OP_START) begin
      rx_phase = PH_HDR1;
      rx_ticks = 8'd0;
      rx_nparam = 0;
      return;
    end
    if (rx_phase == PH_IDLE) return;
    if (op == OP_TICK) begin
      if (rx_ticks >= tick_limit) begin
        rx_phase = PH_IDLE;
        r.status = ST_TIMEOUT;
        due_results.push_back(r);
      end else begin
        rx_ticks = rx_ticks + 8'd1;
      end
      return;
    end
    if (op != OP_BYTE) return;
    case (rx_phase)
      PH_HDR1: if (b == HEADER_BYTE) rx_phase = PH_HDR2;
      PH_HDR2: rx_phase = (b == HEADER_BYTE) ? PH_ID : PH_HDR1;
      PH_ID: begin
        rx_id = b;
        rx_sum = b;
        rx_phase = PH_LEN;
      end
      PH_LEN: begin
        rx_len = b;
        if (b < MIN_LENGTH || b > MAX_LEN) begin
          rx_phase = PH_IDLE;
          r.status = ST_BADLEN;
          r.servo_id = rx_id;
          due_results.push_back(r);
        end else begin
          rx_sum = rx_sum + b;
          rx_ticks = 8'd0;
          rx_phase = PH_ERR;
        end
      end
      PH_ERR: begin
        rx_err = b;
        rx_sum = rx_sum + b;
        rx_nparam = 0;
        rx_phase = (rx_len > MIN_LENGTH) ? PH_PARAM : PH_CHK;
      end
      PH_PARAM: begin
        rx_params[rx_nparam] = b;
        rx_sum = rx_sum + b;
        rx_nparam++;
        if (rx_nparam + 2 >= rx_len) rx_phase = PH_CHK;
      end
      PH_CHK: begin
        want_chk = ~rx_sum;
        if (want_chk != b) st = ST_BADSUM;
        else if (rx_id != want_id) st = ST_IDMISMATCH;
        else if (rx_err != 8'd0) st = ST_SERVOERR;
        else st = ST_OK;
        rx_phase = PH_IDLE;
        n = rx_len - 2;
        r.status = st;
        r.servo_id = rx_id;
        r.error_flags = rx_err;
        if (n == 0) begin
          due_results.push_back(r);
        end else begin
          for (int i = 0; i < n; i++) begin
            r.param_byte = rx_params[i];
            r.param_index = 3'(i);
            r.param_count = 3'(n);
            r.last = (i == n - 1);
            due_results.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic string fmt_result(servo_result_t r);
    return $sformatf("status=%0d id=%02h err=%02h param=%02h idx=%0d count=%0d last=%0d",
                     r.status, r.servo_id, r.error_flags, r.param_byte, r.param_index,
                     r.param_count, r.last);
  endfunction

  // sender
  always @(posedge clk) begin : drive
    rx_item_t item;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.operation <= OP_BYTE;
      in_ch.rx_byte <= 8'h00;
    end else begin
      if (in_ch.valid && in_ch.ready) parse_rx_item(in_ch.operation, in_ch.rx_byte);
      if (!in_ch.valid || in_ch.ready) begin
        if (rx_feed.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          item = rx_feed.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.operation <= item.op;
          in_ch.rx_byte <= item.data;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin : watch
    servo_result_t got;
    servo_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.status = status_t'(out_ch.status);
        got.servo_id = out_ch.servo_id;
        got.error_flags = out_ch.error_flags;
        got.param_byte = out_ch.param_byte;
        got.param_index = out_ch.param_index;
        got.param_count = out_ch.param_count;
        got.last = out_ch.last;
        if (due_results.size() == 0) begin
          if (fail_cnt < 10) $display("unexpected result: %s", fmt_result(got));
          fail_cnt++;
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            if (fail_cnt < 10) begin
              $display("result mismatch");
              $display("  expected %s", fmt_result(want));
              $display("  actual   %s", fmt_result(got));
            end
            fail_cnt++;
          end
        end
      end
      out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (hold_req && !hold_seen) begin
      hold_left <= 300;
      hold_seen <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic add_item(logic [1:0] op, logic [7:0] b = 8'h00);
    rx_item_t item;
    item.op = op;
    item.data = b;
    rx_feed.push_back(item);
    queued_cnt++;
  endtask

  task automatic sprinkle_ticks(int pct);
    while ($urandom_range(99) < pct) add_item(OP_TICK);
  endtask

  task automatic add_packet(logic [7:0] id, logic [7:0] len, logic [7:0] err, bit bad_sum,
                            int tick_pct);
    logic [7:0] sum;
    logic [7:0] b;
    add_item(OP_BYTE, HEADER_BYTE);
    add_item(OP_BYTE, HEADER_BYTE);
    sprinkle_ticks(tick_pct);
    add_item(OP_BYTE, id);
    sum = id;
    sprinkle_ticks(tick_pct);
    add_item(OP_BYTE, len);
    if (len < MIN_LENGTH || len > MAX_LEN) return;
    sum = sum + len;
    sprinkle_ticks(tick_pct);
    add_item(OP_BYTE, err);
    sum = sum + err;
    for (int i = 0; i < len - 2; i++) begin
      b = 8'($urandom);
      sprinkle_ticks(tick_pct);
      add_item(OP_BYTE, b);
      sum = sum + b;
    end
    sum = ~sum;
    if (bad_sum) sum = sum ^ 8'($urandom_range(255, 1));
    sprinkle_ticks(tick_pct);
    add_item(OP_BYTE, sum);
  endtask

  task automatic add_random_traffic(int n_items, int tick_pct);
    int first;
    int pick;
    int len;
    logic [7:0] id;
    logic [7:0] err;
    first = queued_cnt;
    while (queued_cnt - first < n_items) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        add_item(OP_START);
        if ($urandom_range(4) == 0) begin
          add_item(OP_BYTE, 8'($urandom_range(254)));
          add_item(OP_BYTE, HEADER_BYTE);
          add_item(OP_BYTE, 8'($urandom_range(254)));
        end
        if ($urandom_range(9) == 0) begin
          case ($urandom_range(3))
            0: len = 0;
            1: len = 1;
            2: len = MAX_LEN + 1;
            default: len = $urandom_range(255, MAX_LEN + 1);
          endcase
        end else begin
          len = $urandom_range(MAX_LEN, MIN_LENGTH);
        end
        id = ($urandom_range(4) == 0) ? 8'($urandom) : want_id;
        err = ($urandom_range(4) == 0) ? 8'($urandom) : 8'h00;
        add_packet(id, 8'(len), err, $urandom_range(7) == 0, tick_pct);
      end else if (pick < 80) begin
        // abandoned packet; the next start re-arms
        add_item(OP_START);
        add_item(OP_BYTE, HEADER_BYTE);
        add_item(OP_BYTE, HEADER_BYTE);
        repeat ($urandom_range(4)) add_item(OP_BYTE, 8'($urandom));
      end else if (pick < 90) begin
        add_item(OP_START);
        repeat ($urandom_range(12, 1)) add_item(OP_TICK);
      end else begin
        repeat ($urandom_range(4, 1)) add_item(2'($urandom), 8'($urandom));
      end
    end
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_EXPECTED_ID) want_id = val;
    else tick_limit = val;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (rx_feed.size() != 0 || in_ch.valid || due_results.size() != 0) @(negedge clk);
    repeat (32) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [7:0] full_packet [12];
    full_packet = '{8'hFF, 8'hFF, 8'hFF, 8'h08, 8'hFF, 8'h00,
                    8'hFF, 8'hAA, 8'h55, 8'h01, 8'h80, 8'h7A};
    src_idle_pct = 32;
    sink_idle_pct = 50;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    write_reg(CFG_TIMEOUT_TICKS, 8'd1);
    @(negedge clk);
    // disarmed: ignored, as is the unused opcode
    add_item(OP_TICK);
    add_item(OP_BYTE, HEADER_BYTE);
    add_item(OP_UNUSED, 8'hFF);
    // junk dropped, broken header, re-arm mid-hunt, length too short
    add_item(OP_START);
    add_item(OP_BYTE, 8'h00);
    add_item(OP_BYTE, HEADER_BYTE);
    add_item(OP_BYTE, 8'h12);
    add_item(OP_START);
    add_item(OP_BYTE, HEADER_BYTE);
    add_item(OP_BYTE, HEADER_BYTE);
    add_item(OP_BYTE, 8'h00);
    add_item(OP_BYTE, 8'h01);
    // timeout
    add_item(OP_START);
    add_item(OP_TICK);
    add_item(OP_TICK);
    // full-size packet, all-ones id and error
    add_item(OP_START);
    foreach (full_packet[i]) add_item(OP_BYTE, full_packet[i]);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          write_reg(CFG_EXPECTED_ID, 8'h01);
          write_reg(CFG_TIMEOUT_TICKS, 8'd255);
        end
        1: begin
          write_reg(CFG_EXPECTED_ID, 8'h00);
          write_reg(CFG_TIMEOUT_TICKS, 8'd2);
        end
        2: begin
          write_reg(CFG_EXPECTED_ID, 8'hFF);
          write_reg(CFG_TIMEOUT_TICKS, 8'd1);
          src_idle_pct = 50;
          sink_idle_pct = 32;
        end
        3: begin
          write_reg(CFG_EXPECTED_ID, 8'($urandom));
          write_reg(CFG_TIMEOUT_TICKS, 8'($urandom_range(255, 1)));
        end
        4: begin
          write_reg(CFG_EXPECTED_ID, 8'h01);
          write_reg(CFG_TIMEOUT_TICKS, 8'd10);
          src_idle_pct = 0;
          sink_idle_pct = 0;
        end
        default: begin
          write_reg(CFG_EXPECTED_ID, 8'($urandom));
          write_reg(CFG_TIMEOUT_TICKS, 8'($urandom_range(8, 1)));
        end
      endcase
      @(negedge clk);
      // long receiver stall so the input backs up
      if (p == 1) hold_req = 1'b1;
      add_random_traffic(22, (p == 0) ? 5 : 10);
      wait_drained();
    end

    if (fail_cnt == 0 && due_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/ssprx_pkg.sv
sv/ssprx_in_if.sv
sv/ssprx_out_if.sv
sv/ssprx_front.sv
sv/ssprx_queue.sv
sv/ssprx_back.sv
sv/servo_status_packet_receiver_top.sv
verif/testbench.sv
